FILE: hdl/bfer_pkg.sv
// bfer_pkg: shared constants and the arctangent table for the body-frame
// error rotation block. No dependencies; used by every file under hdl/.
package bfer_pkg;

	localparam int ROTATION_STEPS_DEF = 16;
	localparam int POSITION_BITS_DEF  = 32;

	localparam int HEADING_W   = 16;
	// binary angle inside the rotator: 2^31 is a half turn
	localparam int Z_W         = HEADING_W + 1 + 16;
	// rotator x/y are signed Q1.30
	localparam int CW          = 32;
	localparam int FRAC_W      = 30;
	localparam int ATAN_W      = 30;
	localparam int ATAN_ENTRIES = 24;
	localparam int ATAN_IDX_W  = 5;

	// reciprocal of the limiting rotator gain, Q1.30
	localparam logic signed [CW-1:0] GAIN_Q30 = 32'sd652032874;

	// quarter turn in heading units
	localparam logic signed [HEADING_W:0] QUARTER_TURN = 17'sd16384;
	localparam logic signed [HEADING_W:0] HALF_TURN    = 17'sd32768;

	// round(atan(2^-i) * 2^31 / pi)
	function automatic logic [ATAN_W-1:0] atan_val(input logic [ATAN_IDX_W-1:0] i);
		logic [ATAN_W-1:0] v;
		case (i)
			5'd0:  v = 30'd536870912;
			5'd1:  v = 30'd316933406;
			5'd2:  v = 30'd167458907;
			5'd3:  v = 30'd85004756;
			5'd4:  v = 30'd42667331;
			5'd5:  v = 30'd21354465;
			5'd6:  v = 30'd10679838;
			5'd7:  v = 30'd5340245;
			5'd8:  v = 30'd2670163;
			5'd9:  v = 30'd1335087;
			5'd10: v = 30'd667544;
			5'd11: v = 30'd333772;
			5'd12: v = 30'd166886;
			5'd13: v = 30'd83443;
			5'd14: v = 30'd41722;
			5'd15: v = 30'd20861;
			5'd16: v = 30'd10430;
			5'd17: v = 30'd5215;
			5'd18: v = 30'd2608;
			5'd19: v = 30'd1304;
			5'd20: v = 30'd652;
			5'd21: v = 30'd326;
			5'd22: v = 30'd163;
			5'd23: v = 30'd81;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

FILE: hdl/bfer_cordic.sv
// bfer_cordic: unrolled rotation-mode CORDIC, one micro-rotation per stage,
// with a sideband bus carried alongside. Depends on bfer_pkg.
module bfer_cordic #(
	parameter int STEPS  = bfer_pkg::ROTATION_STEPS_DEF,
	parameter int SIDE_W = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic signed [bfer_pkg::Z_W-1:0] in_z,
	input  logic [SIDE_W-1:0]               in_side,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [bfer_pkg::CW-1:0]  out_x,
	output logic signed [bfer_pkg::CW-1:0]  out_y,
	output logic [SIDE_W-1:0]               out_side
);

	localparam int NS = (STEPS < bfer_pkg::ATAN_ENTRIES) ? STEPS : bfer_pkg::ATAN_ENTRIES;
	localparam int CW = bfer_pkg::CW;
	localparam int ZW = bfer_pkg::Z_W;

	logic signed [CW-1:0] x_s [0:NS];
	logic signed [CW-1:0] y_s [0:NS];
	logic signed [ZW-1:0] z_s [0:NS];
	logic [SIDE_W-1:0]    side_s [0:NS];
	logic [NS:0]          v_s;
	logic [NS+1:1]        en;

	assign x_s[0]    = bfer_pkg::GAIN_Q30;
	assign y_s[0]    = '0;
	assign z_s[0]    = in_z;
	assign side_s[0] = in_side;
	assign v_s[0]    = in_valid;
	assign en[NS+1]  = out_ready;
	assign in_ready  = en[1];

	genvar k;
	generate
		for (k = 1; k <= NS; k++) begin : g_step
			localparam logic signed [ZW-1:0] ATAN_K = $signed({{(ZW - bfer_pkg::ATAN_W){1'b0}},
				bfer_pkg::atan_val(bfer_pkg::ATAN_IDX_W'(k - 1))});
			logic signed [CW-1:0] xs;
			logic signed [CW-1:0] ys;
			logic                 pos;

			assign xs    = x_s[k-1] >>> (k - 1);
			assign ys    = y_s[k-1] >>> (k - 1);
			assign pos   = ~z_s[k-1][ZW-1];
			// a stage takes new data when empty or when its successor moves
			assign en[k] = ~v_s[k] | en[k+1];

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[k] <= 1'b0;
				end else if (en[k]) begin
					v_s[k] <= v_s[k-1];
				end
			end

			always_ff @(posedge clk) begin
				if (en[k] && v_s[k-1]) begin
					x_s[k]    <= pos ? (x_s[k-1] - ys) : (x_s[k-1] + ys);
					y_s[k]    <= pos ? (y_s[k-1] + xs) : (y_s[k-1] - xs);
					z_s[k]    <= pos ? (z_s[k-1] - ATAN_K) : (z_s[k-1] + ATAN_K);
					side_s[k] <= side_s[k-1];
				end
			end
		end
	endgenerate

	assign out_valid = v_s[NS];
	assign out_x     = x_s[NS];
	assign out_y     = y_s[NS];
	assign out_side  = side_s[NS];

endmodule

FILE: hdl/bfer_mac.sv
// bfer_mac: applies the half-turn flip, forms the rotated error with split
// partial products, rounds and saturates. Five pipeline stages. Uses bfer_pkg.
module bfer_mac #(
	parameter int POSITION_BITS = bfer_pkg::POSITION_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [POSITION_BITS:0]     dx,
	input  logic signed [POSITION_BITS:0]     dy,
	input  logic                              flip,
	input  logic signed [bfer_pkg::CW-1:0]    cos_in,
	input  logic signed [bfer_pkg::CW-1:0]    sin_in,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [POSITION_BITS-1:0]   err_forward,
	output logic signed [POSITION_BITS-1:0]   err_lateral
);

	localparam int P     = POSITION_BITS;
	localparam int CW    = bfer_pkg::CW;
	localparam int FW    = bfer_pkg::FRAC_W;
	localparam int DW    = P + 1;
	localparam int LOW   = DW / 2;
	localparam int HIW   = DW - LOW;
	localparam int HP_W  = HIW + CW;
	localparam int LP_W  = LOW + 1 + CW;
	localparam int SUM_W = DW + CW + 2;
	localparam int RV_W  = SUM_W - FW;
	localparam int NST   = 5;

	localparam logic signed [SUM_W-1:0] HALF_LSB =
		$signed({{(SUM_W - FW){1'b0}}, 1'b1, {(FW - 1){1'b0}}});

	logic [NST:1]   v_m;
	logic [NST+1:1] en;
	logic [NST:0]   vin;

	assign vin      = {v_m, in_valid};
	assign en[NST+1] = out_ready;
	assign in_ready = en[1];

	genvar k;
	generate
		for (k = 1; k <= NST; k++) begin : g_ctl
			assign en[k] = ~v_m[k] | en[k+1];
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_m[k] <= 1'b0;
				end else if (en[k]) begin
					v_m[k] <= vin[k-1];
				end
			end
		end
	endgenerate

	// stage 1: undo the half-turn fold
	logic signed [DW-1:0] dx_s1, dy_s1;
	logic signed [CW-1:0] c_s1, s_s1;

	always_ff @(posedge clk) begin
		if (en[1] && in_valid) begin
			dx_s1 <= dx;
			dy_s1 <= dy;
			c_s1  <= flip ? -cos_in : cos_in;
			s_s1  <= flip ? -sin_in : sin_in;
		end
	end

	// stage 2: partial products, operands split into high signed and low unsigned halves
	logic signed [HIW-1:0] dxh, dyh;
	logic signed [LOW:0]   dxl, dyl;

	assign dxh = dx_s1[DW-1:LOW];
	assign dyh = dy_s1[DW-1:LOW];
	assign dxl = $signed({1'b0, dx_s1[LOW-1:0]});
	assign dyl = $signed({1'b0, dy_s1[LOW-1:0]});

	logic signed [HP_W-1:0] hxc_s2, hys_s2, hxs_s2, hyc_s2;
	logic signed [LP_W-1:0] lxc_s2, lys_s2, lxs_s2, lyc_s2;

	always_ff @(posedge clk) begin
		if (en[2] && v_m[1]) begin
			hxc_s2 <= HP_W'(dxh) * HP_W'(c_s1);
			hys_s2 <= HP_W'(dyh) * HP_W'(s_s1);
			hxs_s2 <= HP_W'(dxh) * HP_W'(s_s1);
			hyc_s2 <= HP_W'(dyh) * HP_W'(c_s1);
			lxc_s2 <= LP_W'(dxl) * LP_W'(c_s1);
			lys_s2 <= LP_W'(dyl) * LP_W'(s_s1);
			lxs_s2 <= LP_W'(dxl) * LP_W'(s_s1);
			lyc_s2 <= LP_W'(dyl) * LP_W'(c_s1);
		end
	end

	// stage 3: combine the two terms of each output per half
	logic signed [HP_W:0] fh_s3, lh_s3;
	logic signed [LP_W:0] fl_s3, ll_s3;

	always_ff @(posedge clk) begin
		if (en[3] && v_m[2]) begin
			fh_s3 <= (HP_W+1)'(hxc_s2) + (HP_W+1)'(hys_s2);
			lh_s3 <= (HP_W+1)'(hyc_s2) - (HP_W+1)'(hxs_s2);
			fl_s3 <= (LP_W+1)'(lxc_s2) + (LP_W+1)'(lys_s2);
			ll_s3 <= (LP_W+1)'(lyc_s2) - (LP_W+1)'(lxs_s2);
		end
	end

	// stage 4: full-width sum plus half an LSB for round-half-up
	logic signed [SUM_W-1:0] fsum_s4, lsum_s4;

	always_ff @(posedge clk) begin
		if (en[4] && v_m[3]) begin
			fsum_s4 <= (SUM_W'(fh_s3) <<< LOW) + SUM_W'(fl_s3) + HALF_LSB;
			lsum_s4 <= (SUM_W'(lh_s3) <<< LOW) + SUM_W'(ll_s3) + HALF_LSB;
		end
	end

	// stage 5: drop the fraction and clamp to the output range
	logic signed [RV_W-1:0] frv, lrv;
	logic                   fovf, lovf;
	logic signed [P-1:0]    fsat, lsat;
	logic signed [P-1:0]    fwd_s5, lat_s5;

	assign frv  = fsum_s4[SUM_W-1:FW];
	assign lrv  = lsum_s4[SUM_W-1:FW];
	// overflow when the bits above the output sign are not all copies of it
	assign fovf = ~((&frv[RV_W-1:P-1]) | ~(|frv[RV_W-1:P-1]));
	assign lovf = ~((&lrv[RV_W-1:P-1]) | ~(|lrv[RV_W-1:P-1]));
	assign fsat = frv[RV_W-1] ? $signed({1'b1, {(P-1){1'b0}}}) : $signed({1'b0, {(P-1){1'b1}}});
	assign lsat = lrv[RV_W-1] ? $signed({1'b1, {(P-1){1'b0}}}) : $signed({1'b0, {(P-1){1'b1}}});

	always_ff @(posedge clk) begin
		if (en[5] && v_m[4]) begin
			fwd_s5 <= fovf ? fsat : frv[P-1:0];
			lat_s5 <= lovf ? lsat : lrv[P-1:0];
		end
	end

	assign out_valid   = v_m[5];
	assign err_forward = fwd_s5;
	assign err_lateral = lat_s5;

endmodule

FILE: hdl/body_frame_error_rotation.sv
// body_frame_error_rotation: top level; world-frame position error rotated
// into the body frame. Instantiates bfer_cordic and bfer_mac; uses bfer_pkg.
//
//  channel  direction  handshake            payload
//  input    in         in_valid / in_ready  ref_x, meas_x, ref_y, meas_y, heading
//  output   out        out_valid/out_ready  err_forward, err_lateral
//
// One transfer per cycle sustained while out_ready stays high; the stages are the entry stage,
// one CORDIC micro-rotation per stage, then five multiply/round stages.
// arst_n clears only the stage valid bits; data registers are not reset.
// Each stage loads when it is empty or its successor moves, so bubbles are
// squeezed out and a stall at out_ready backs up without loss or repeats.
module body_frame_error_rotation #(
	parameter int ROTATION_STEPS = bfer_pkg::ROTATION_STEPS_DEF,
	parameter int POSITION_BITS  = bfer_pkg::POSITION_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [POSITION_BITS-1:0]      ref_x,
	input  logic signed [POSITION_BITS-1:0]      meas_x,
	input  logic signed [POSITION_BITS-1:0]      ref_y,
	input  logic signed [POSITION_BITS-1:0]      meas_y,
	input  logic signed [bfer_pkg::HEADING_W-1:0] heading,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [POSITION_BITS-1:0]      err_forward,
	output logic signed [POSITION_BITS-1:0]      err_lateral
);

	localparam int P      = POSITION_BITS;
	localparam int DW     = P + 1;
	localparam int HW     = bfer_pkg::HEADING_W;
	localparam int ZW     = bfer_pkg::Z_W;
	localparam int SIDE_W = 2 * DW + 1;

	// entry stage: differences and heading fold into the right half plane
	logic signed [HW:0]   h17, hf;
	logic                 fold;
	logic signed [DW-1:0] dx_s1, dy_s1;
	logic signed [ZW-1:0] z_s1;
	logic                 flip_s1;
	logic                 v_s1;
	logic                 en_s1;
	logic                 cor_in_ready;

	assign h17  = {heading[HW-1], heading};
	assign fold = (h17 > bfer_pkg::QUARTER_TURN) | (h17 < -bfer_pkg::QUARTER_TURN);
	assign hf   = (h17 > bfer_pkg::QUARTER_TURN) ? (h17 - bfer_pkg::HALF_TURN) :
	              (h17 < -bfer_pkg::QUARTER_TURN) ? (h17 + bfer_pkg::HALF_TURN) : h17;

	assign en_s1    = ~v_s1 | cor_in_ready;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			dx_s1   <= {ref_x[P-1], ref_x} - {meas_x[P-1], meas_x};
			dy_s1   <= {ref_y[P-1], ref_y} - {meas_y[P-1], meas_y};
			z_s1    <= {hf, 16'b0};
			flip_s1 <= fold;
		end
	end

	logic                          cor_valid, mac_ready;
	logic signed [bfer_pkg::CW-1:0] cor_x, cor_y;
	logic [SIDE_W-1:0]             cor_side;

	bfer_cordic #(
		.STEPS  (ROTATION_STEPS),
		.SIDE_W (SIDE_W)
	) u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1),
		.in_ready  (cor_in_ready),
		.in_z      (z_s1),
		.in_side   ({flip_s1, dx_s1, dy_s1}),
		.out_valid (cor_valid),
		.out_ready (mac_ready),
		.out_x     (cor_x),
		.out_y     (cor_y),
		.out_side  (cor_side)
	);

	bfer_mac #(
		.POSITION_BITS (POSITION_BITS)
	) u_mac (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (cor_valid),
		.in_ready    (mac_ready),
		.dx          ($signed(cor_side[2*DW-1:DW])),
		.dy          ($signed(cor_side[DW-1:0])),
		.flip        (cor_side[2*DW]),
		.cos_in      (cor_x),
		.sin_in      (cor_y),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.err_forward (err_forward),
		.err_lateral (err_lateral)
	);

endmodule

FILE: test/body_frame_error_rotation_tb.sv
// Self-checking testbench for body_frame_error_rotation: drives random and corner-case
// position/heading transfers, predicts the body-frame error in SV and checks each result.
// Depends on hdl/bfer_pkg.sv and hdl/body_frame_error_rotation.sv.
`timescale 1ns / 100ps

module body_frame_error_rotation_tb;

	localparam int POS_W   = bfer_pkg::POSITION_BITS_DEF;
	localparam int STEPS   = bfer_pkg::ROTATION_STEPS_DEF;
	localparam int HW      = bfer_pkg::HEADING_W;
	localparam int LATENCY = 1 + STEPS + 5;
	localparam int FRAC    = 30;
	localparam int HOLD_CYCLES = 200;
	localparam int RANDOM_PER_PHASE = 510;

	typedef logic signed [127:0] wide_t;

	localparam logic signed [POS_W-1:0] PMAX = {1'b0, {(POS_W-1){1'b1}}};
	localparam logic signed [POS_W-1:0] PMIN = {1'b1, {(POS_W-1){1'b0}}};
	localparam int ONE = 65536;

	localparam wide_t ROUND_HALF = wide_t'(1) <<< (FRAC - 1);
	localparam wide_t POS_HI = (wide_t'(1) <<< (POS_W - 1)) - 1;
	localparam wide_t POS_LO = -(wide_t'(1) <<< (POS_W - 1));

	localparam longint GAIN = 652032874;
	localparam longint QTR_TURN = 16384;
	localparam longint HALF_TURN = 32768;

	// round(atan(2^-i) * 2^31 / pi)
	localparam longint ARCTAN_Q31 [0:23] = '{
		536870912, 316933406, 167458907, 85004756,
		42667331, 21354465, 10679838, 5340245,
		2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861,
		10430, 5215, 2608, 1304,
		652, 326, 163, 81
	};

	localparam logic signed [HW-1:0] HEADING_EDGES [0:8] = '{
		16'sd0, 16'sd16384, -16'sd16384, 16'sd16385, -16'sd16385,
		16'h8000, 16'sd32767, 16'sd8192, -16'sd8192
	};

	typedef struct packed {
		logic signed [POS_W-1:0] ref_x;
		logic signed [POS_W-1:0] meas_x;
		logic signed [POS_W-1:0] ref_y;
		logic signed [POS_W-1:0] meas_y;
		logic signed [HW-1:0]    heading;
	} pose_item_t;

	typedef struct packed {
		logic signed [POS_W-1:0] fwd;
		logic signed [POS_W-1:0] lat;
	} body_err_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [POS_W-1:0] ref_x = '0;
	logic signed [POS_W-1:0] meas_x = '0;
	logic signed [POS_W-1:0] ref_y = '0;
	logic signed [POS_W-1:0] meas_y = '0;
	logic signed [HW-1:0] heading = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [POS_W-1:0] err_forward;
	logic signed [POS_W-1:0] err_lateral;

	pose_item_t pending_items[$];
	body_err_t body_err_q[$];
	pose_item_t cur_pose;

	int send_idle_pct = 9;
	int recv_stall_pct = 50;
	bit rx_hold_req = 1'b0;
	bit rx_hold_seen = 1'b0;
	int rx_hold_left = 0;

	int n_errors = 0;
	int n_sent = 0;
	int n_checked = 0;
	int n_input_stalls = 0;

	body_frame_error_rotation #(
		.ROTATION_STEPS(STEPS),
		.POSITION_BITS(POS_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.ref_x(ref_x),
		.meas_x(meas_x),
		.ref_y(ref_y),
		.meas_y(meas_y),
		.heading(heading),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.err_forward(err_forward),
		.err_lateral(err_lateral)
	);

	always #5 clk = ~clk;

	function automatic logic signed [POS_W-1:0] round_saturate(wide_t acc);
		wide_t v;
		v = (acc + ROUND_HALF) >>> FRAC;
		if (v > POS_HI)
			return PMAX;
		if (v < POS_LO)
			return PMIN;
		return v[POS_W-1:0];
	endfunction

	// sin/cos by rotation-mode CORDIC, then exact products with one final rounding
	function automatic body_err_t rotate_error(pose_item_t it);
		longint dx, dy, hd, x, y, z, xs, ys;
		bit flip;
		body_err_t r;
		dx = longint'(it.ref_x) - longint'(it.meas_x);
		dy = longint'(it.ref_y) - longint'(it.meas_y);
		hd = longint'(it.heading);
		flip = 1'b0;
		// fold into [-quarter, quarter]; minus pi lands on zero
		if (hd > QTR_TURN) begin
			hd = hd - HALF_TURN;
			flip = 1'b1;
		end else if (hd < -QTR_TURN) begin
			hd = hd + HALF_TURN;
			flip = 1'b1;
		end
		z = hd * 65536;
		x = GAIN;
		y = 0;
		for (int i = 0; i < STEPS && i < 24; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x = x - ys;
				y = y + xs;
				z = z - ARCTAN_Q31[i];
			end else begin
				x = x + ys;
				y = y - xs;
				z = z + ARCTAN_Q31[i];
			end
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		r.fwd = round_saturate(wide_t'(dx) * wide_t'(x) + wide_t'(dy) * wide_t'(y));
		r.lat = round_saturate(wide_t'(dy) * wide_t'(x) - wide_t'(dx) * wide_t'(y));
		return r;
	endfunction

	function automatic logic signed [POS_W-1:0] extreme_position();
		case ($urandom_range(5))
			0: return PMAX;
			1: return PMIN;
			2: return '0;
			3: return -1;
			4: return PMAX - 1;
			default: return $urandom;
		endcase
	endfunction

	function automatic pose_item_t random_pose();
		pose_item_t it;
		logic signed [POS_W-1:0] bx, by;
		bx = $urandom;
		by = $urandom;
		it.heading = HW'($urandom);
		if ($urandom_range(7) == 0)
			it.heading = HEADING_EDGES[$urandom_range(8)];
		case ($urandom_range(9))
			0, 1, 2, 3, 4, 5: begin
				// nearby positions, error magnitude spread over many octaves
				it.meas_x = bx;
				it.meas_y = by;
				it.ref_x = bx + ($signed($urandom) >>> $urandom_range(31));
				it.ref_y = by + ($signed($urandom) >>> $urandom_range(31));
			end
			6, 7: begin
				it.ref_x = $urandom;
				it.meas_x = $urandom;
				it.ref_y = $urandom;
				it.meas_y = $urandom;
			end
			8: begin
				it.ref_x = extreme_position();
				it.meas_x = extreme_position();
				it.ref_y = extreme_position();
				it.meas_y = extreme_position();
			end
			default: begin
				// one axis without error
				it.ref_x = bx;
				it.meas_x = bx;
				it.meas_y = by;
				it.ref_y = by + ($signed($urandom) >>> $urandom_range(31));
			end
		endcase
		return it;
	endfunction

	task automatic add_pose(input logic signed [POS_W-1:0] rx, mx, ry, my,
			input logic signed [HW-1:0] h);
		pending_items.push_back(pose_item_t'{rx, mx, ry, my, h});
	endtask

	task automatic report_mismatch(input string what, input logic signed [POS_W-1:0] got,
			input logic signed [POS_W-1:0] want);
		// cap the log; every mismatch is still counted
		if (n_errors < 100)
			$display("%0t ns: %s: got %0d, expected %0d", $realtime, what, got, want);
		n_errors++;
	endtask

	task automatic drain_pipeline();
		do
			@(negedge clk);
		while (pending_items.size() != 0 || in_valid || body_err_q.size() != 0);
	endtask

	// driver: offers queued items, records the expected result on each transfer
	always @(posedge clk) begin
		pose_item_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_ready)
				n_input_stalls++;
			if (!in_valid || in_ready) begin
				if (in_valid) begin
					body_err_q.push_back(rotate_error(cur_pose));
					n_sent++;
				end
				if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = pending_items.pop_front();
					cur_pose <= nxt;
					ref_x <= nxt.ref_x;
					meas_x <= nxt.meas_x;
					ref_y <= nxt.ref_y;
					meas_y <= nxt.meas_y;
					heading <= nxt.heading;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks each result transfer, paces out_ready
	always @(posedge clk) begin
		body_err_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (body_err_q.size() == 0) begin
					report_mismatch("result with no pending item, err_forward", err_forward, '0);
				end else begin
					want = body_err_q.pop_front();
					if (err_forward !== want.fwd)
						report_mismatch("err_forward", err_forward, want.fwd);
					if (err_lateral !== want.lat)
						report_mismatch("err_lateral", err_lateral, want.lat);
					n_checked++;
				end
			end
			if (rx_hold_req && !rx_hold_seen) begin
				rx_hold_seen <= 1'b1;
				rx_hold_left <= HOLD_CYCLES;
				out_ready <= 1'b0;
			end else if (rx_hold_left != 0) begin
				rx_hold_left <= rx_hold_left - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	initial begin
		#2_000_000;
		$display("body_frame_error_rotation_tb: done, errors");
		$finish;
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// corner cases: zero error, unit error at every special heading, saturation
		add_pose(0, 0, 0, 0, '0);
		for (int i = 0; i < 9; i++)
			add_pose(ONE, 0, 0, 0, HEADING_EDGES[i]);
		add_pose(0, 0, ONE, 0, 16'sd16384);
		add_pose(0, ONE, 0, -ONE, 16'sd12345);
		add_pose(PMAX, PMIN, PMAX, PMIN, '0);
		add_pose(PMAX, PMIN, PMAX, PMIN, 16'sd8192);
		add_pose(PMIN, PMAX, PMIN, PMAX, 16'h8000);
		add_pose(PMIN, PMAX, PMAX, PMIN, -16'sd8192);
		add_pose(PMAX, PMAX, PMAX, PMAX, 16'sd32767);
		add_pose(PMIN, PMIN, PMIN, PMIN, 16'h8000);
		add_pose(PMAX, 0, 0, PMIN, 16'sd16384);
		add_pose(-1, 0, 0, 1, -16'sd16384);
		add_pose(PMAX, PMIN, 0, 0, 16'sd16385);
		for (int k = 0; k < RANDOM_PER_PHASE; k++)
			pending_items.push_back(random_pose());
		drain_pipeline();

		send_idle_pct = 50;
		recv_stall_pct = 9;
		for (int k = 0; k < RANDOM_PER_PHASE; k++)
			pending_items.push_back(random_pose());
		drain_pipeline();

		// full rate, opening with a long output hold to back the pipe up
		send_idle_pct = 0;
		recv_stall_pct = 0;
		rx_hold_req = 1'b1;
		for (int k = 0; k < RANDOM_PER_PHASE; k++)
			pending_items.push_back(random_pose());
		drain_pipeline();

		repeat (3 * LATENCY) @(posedge clk);
		$display("%0d transfers sent, %0d results checked, pacing 9/50, 50/9 and full rate",
			n_sent, n_checked);
		$display("%0d-cycle output hold, input held off on %0d cycles, %0d mismatches",
			HOLD_CYCLES, n_input_stalls, n_errors);
		if (n_errors == 0 && body_err_q.size() == 0)
			$display("body_frame_error_rotation_tb: done, clean");
		else
			$display("body_frame_error_rotation_tb: done, errors");
		$finish;
	end

endmodule
